// ===== design/bsi_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the
// impaired barometer block. No dependencies.
package bsi_pkg;

    // Ring of stored samples and stamps
    localparam int RingDepth = 64;
    localparam int IdxW      = $clog2(RingDepth);
    localparam int SlotW     = $clog2(RingDepth + 1);

    // Timing windows in ms
    localparam int StoreGapMs  = 10;
    localparam int ReportGapMs = 100;
    localparam int MatchWinMs  = 200;

    // Divide-by-constant unit: dividend width, quotient bits per cycle, divisor
    localparam int DivW     = 52;
    localparam int DivDigit = 4;
    localparam int DivSteps = DivW / DivDigit;
    localparam int DivCntW  = $clog2(DivSteps);
    localparam int Divisor  = 1000;
    localparam int RemW     = 10;

    // Configuration port
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 25;

    localparam logic [CfgIdxW-1:0] CFG_DISABLE = CfgIdxW'(0);
    localparam logic [CfgIdxW-1:0] CFG_DRIFT   = CfgIdxW'(1);
    localparam logic [CfgIdxW-1:0] CFG_NOISE   = CfgIdxW'(2);
    localparam logic [CfgIdxW-1:0] CFG_GLITCH  = CfgIdxW'(3);
    localparam logic [CfgIdxW-1:0] CFG_DELAY   = CfgIdxW'(4);

    // Dividend select for the shared divider
    typedef enum logic [1:0] {
        DSEL_DRIFT  = 2'd0,
        DSEL_SMOOTH = 2'd1,
        DSEL_X      = 2'd2
    } t_dsel;

    // Controller to datapath commands
    typedef struct packed {
        logic            in_load;
        logic            mul;
        logic            scan_clr;
        logic            div_start;
        t_dsel           div_sel;
        logic            add_drift;
        logic            add_noise;
        logic            add_glitch;
        logic            sm_latch;
        logic            scan_rd;
        logic [IdxW-1:0] scan_addr;
        logic            cmp_en;
        logic [IdxW-1:0] cmp_idx;
        logic            rd_sample;
        logic            sel_x;
        logic            x_latch;
        logic            smooth;
        logic            out_load;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic disabled;
        logic div_done;
        logic rep_due;
        logic out_busy;
    } t_sts;

endpackage

// ===== design/baro_sensor_impairment_top.sv =====
// Impaired barometer model: top level joining controller and datapath.
// Depends on bsi_pkg, bsi_ctrl, bsi_dp (which holds bsi_div).
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one tick: altitude in mm,
//   time in ms and a Q1.15 noise sample. An item is taken when valid is high
//   and stall is low. Output channel (o_out_valid / i_out_stall) carries the
//   reported altitude, at most one per item and at most one per 100 ms.
//   Config channel (i_cfg_valid / o_cfg_ready) writes one register per cycle;
//   ready is always high. Write only while the block is idle.
// Timing:
//   One item at a time: no new item is taken until the block is back in
//   idle. The stamp scan reads one entry of the 64-entry ring per cycle,
//   and the last divide by 1000 of the smoothing step (13 steps of 4 bits)
//   follows it. A disabled item is taken and dropped without leaving the
//   idle state.
// Reset and stall:
//   Synchronous active-low reset clears config, rings (via valid bits), the
//   average and all timers. If a result is still stalled when the next one is
//   ready, the block holds that result and does not take new items until the
//   output register frees up.
module baro_sensor_impairment_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [31:0]            i_altitude,
    input  logic [31:0]                   i_time_ms,
    input  logic signed [15:0]            i_noise_sample,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [31:0]            o_reported_altitude,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [bsi_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  logic [bsi_pkg::CfgDataW-1:0]  i_cfg_data
);

    bsi_pkg::t_cmd cmd;
    bsi_pkg::t_sts sts;

    bsi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    bsi_dp u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_valid         (i_cfg_valid),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_altitude          (i_altitude),
        .i_time_ms           (i_time_ms),
        .i_noise_sample      (i_noise_sample),
        .i_out_stall         (i_out_stall),
        .o_out_valid         (o_out_valid),
        .o_reported_altitude (o_reported_altitude),
        .i_cmd               (cmd),
        .o_sts               (sts)
    );

    // Config writes are always taken
    assign o_cfg_ready = 1'b1;

endmodule

// ===== design/bsi_div.sv =====
// Signed divide by the constant 1000, truncating toward zero, four quotient
// bits per cycle. Depends on bsi_pkg.
module bsi_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic signed [bsi_pkg::DivW-1:0]  i_dividend,
    output logic                             o_done,
    output logic signed [bsi_pkg::DivW-1:0]  o_quotient
);

    localparam logic [bsi_pkg::RemW:0] DivConst = (bsi_pkg::RemW + 1)'(bsi_pkg::Divisor);

    logic                              r_busy;
    logic                              r_done;
    logic [bsi_pkg::DivCntW-1:0]       r_cnt;
    logic [bsi_pkg::DivW-1:0]          r_dvd;
    logic [bsi_pkg::RemW-1:0]          r_rem;
    logic [bsi_pkg::DivW-1:0]          r_quo;
    logic                              r_neg;

    logic [bsi_pkg::RemW-1:0]          n_rem;
    logic [bsi_pkg::DivDigit-1:0]      n_qbits;
    logic [bsi_pkg::DivW-1:0]          n_mag;

    // One digit: one narrow compare/subtract step per quotient bit on the remainder
    always_comb begin
        logic [bsi_pkg::RemW:0] t;
        n_rem   = r_rem;
        n_qbits = '0;
        for (int k = bsi_pkg::DivDigit - 1; k >= 0; k--) begin
            t = {n_rem, r_dvd[bsi_pkg::DivW - bsi_pkg::DivDigit + k]};
            if (t >= DivConst) begin
                n_rem      = bsi_pkg::RemW'(t - DivConst);
                n_qbits[k] = 1'b1;
            end else begin
                n_rem = t[bsi_pkg::RemW-1:0];
            end
        end
    end

    assign n_mag = i_dividend[bsi_pkg::DivW-1] ? bsi_pkg::DivW'(-i_dividend)
                                               : bsi_pkg::DivW'(i_dividend);

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == bsi_pkg::DivCntW'(bsi_pkg::DivSteps - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    // Operand and quotient shift registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= n_mag;
            r_rem <= '0;
            r_quo <= '0;
            r_neg <= i_dividend[bsi_pkg::DivW-1];
        end else if (r_busy) begin
            r_dvd <= {r_dvd[bsi_pkg::DivW-bsi_pkg::DivDigit-1:0], {bsi_pkg::DivDigit{1'b0}}};
            r_rem <= n_rem;
            r_quo <= {r_quo[bsi_pkg::DivW-bsi_pkg::DivDigit-1:0], n_qbits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? $signed(-r_quo) : $signed(r_quo);

endmodule

// ===== design/bsi_dp.sv =====
// Datapath of the impaired barometer: config registers, impairment math,
// sample/stamp rings, scan compare, smoothing and output register.
// Depends on bsi_pkg and bsi_div.
module bsi_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic [bsi_pkg::CfgIdxW-1:0]    i_cfg_index,
    input  logic [bsi_pkg::CfgDataW-1:0]   i_cfg_data,
    input  logic signed [31:0]             i_altitude,
    input  logic [31:0]                    i_time_ms,
    input  logic signed [15:0]             i_noise_sample,
    input  logic                           i_out_stall,
    output logic                           o_out_valid,
    output logic signed [31:0]             o_reported_altitude,
    input  bsi_pkg::t_cmd                  i_cmd,
    output bsi_pkg::t_sts                  o_sts
);

    localparam logic signed [53:0] Sat32Max = 54'sd2147483647;
    localparam logic signed [53:0] Sat32Min = -54'sd2147483648;
    localparam logic signed [49:0] Sat48Max = 50'sd140737488355327;
    localparam logic signed [49:0] Sat48Min = -50'sd140737488355328;

    // Configuration registers
    logic                    r_disable;
    logic signed [17:0]      r_drift_rate;
    logic [19:0]             r_noise_scale;
    logic signed [24:0]      r_glitch;
    logic [9:0]              r_delay;

    // Item payload and intermediate values
    logic signed [31:0]      r_alt;
    logic [31:0]             r_now;
    logic signed [15:0]      r_noise;
    logic signed [50:0]      r_drift_prod;
    logic signed [36:0]      r_noise_prod;
    logic [31:0]             r_target;
    logic                    r_store;
    logic [bsi_pkg::IdxW-1:0] r_wslot_idx;
    logic signed [31:0]      r_x;
    logic signed [38:0]      r_q_sm;
    logic signed [38:0]      r_q_x;

    // Persistent state
    logic [bsi_pkg::SlotW-1:0] r_slot;
    logic [31:0]             r_last_store;
    logic [31:0]             r_last_rep;
    logic signed [47:0]      r_smoothed;
    logic [bsi_pkg::RingDepth-1:0] r_valid;

    // Rings
    logic [31:0]             stamp_mem  [bsi_pkg::RingDepth];
    logic signed [31:0]      sample_mem [bsi_pkg::RingDepth];
    logic [31:0]             r_stamp_q;
    logic                    r_stamp_v;
    logic signed [31:0]      r_smp_q;
    logic                    r_smp_v;

    // Scan result
    logic [7:0]              r_best_dist;
    logic [bsi_pkg::IdxW-1:0] r_best_idx;
    logic                    r_found;

    // Output register
    logic                    r_out_valid;
    logic signed [31:0]      r_out_data;

    // Divider
    logic signed [bsi_pkg::DivW-1:0] div_dividend;
    logic signed [bsi_pkg::DivW-1:0] div_quo;
    logic                            div_done;

    logic                          n_store;
    logic [bsi_pkg::SlotW-1:0]     n_slot_use;
    logic [bsi_pkg::IdxW-1:0]      n_slot_idx;
    logic signed [36:0]            n_noise_sum;
    logic signed [21:0]            n_noise_term;
    logic signed [31:0]            n_x_drift;
    logic signed [31:0]            n_x_noise;
    logic signed [31:0]            n_x_glitch;
    logic [31:0]                   n_stamp;
    logic [31:0]                   n_d;
    logic [31:0]                   n_dist;
    logic signed [49:0]            n_sm_sum;
    logic signed [47:0]            n_smoothed;
    logic [47:0]                   n_mag;
    logic [48:0]                   n_rnd;
    logic [31:0]                   n_rmag;
    logic signed [31:0]            n_report;

    function automatic logic signed [31:0] sat32(input logic signed [53:0] v);
        if (v > Sat32Max) begin
            return 32'sh7FFF_FFFF;
        end else if (v < Sat32Min) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_disable     <= 1'b0;
            r_drift_rate  <= '0;
            r_noise_scale <= '0;
            r_glitch      <= '0;
            r_delay       <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                bsi_pkg::CFG_DISABLE: r_disable     <= i_cfg_data[0];
                bsi_pkg::CFG_DRIFT:   r_drift_rate  <= $signed(i_cfg_data[17:0]);
                bsi_pkg::CFG_NOISE:   r_noise_scale <= i_cfg_data[19:0];
                bsi_pkg::CFG_GLITCH:  r_glitch      <= $signed(i_cfg_data[24:0]);
                bsi_pkg::CFG_DELAY:   r_delay       <= i_cfg_data[9:0];
                default: ;
            endcase
        end
    end

    // Store decision and slot wrap
    assign n_store    = (r_now - r_last_store) >= 32'(bsi_pkg::StoreGapMs);
    assign n_slot_use = (r_slot >= bsi_pkg::SlotW'(bsi_pkg::RingDepth)) ? '0 : r_slot;
    assign n_slot_idx = n_slot_use[bsi_pkg::IdxW-1:0];

    // Saturating impairment sums; noise term truncates toward zero
    assign n_noise_sum  = r_noise_prod + (r_noise_prod[36] ? 37'sd32767 : 37'sd0);
    assign n_noise_term = n_noise_sum[36:15];
    assign n_x_drift  = sat32(54'(r_alt) + 54'(div_quo));
    assign n_x_noise  = sat32(54'(r_x) + 54'(n_noise_term));
    assign n_x_glitch = sat32(54'(r_x) + 54'(r_glitch));

    // Distance of one stamp to the target, shorter way round
    assign n_stamp = r_stamp_v ? r_stamp_q : 32'd0;
    assign n_d     = r_target - n_stamp;
    assign n_dist  = n_d[31] ? (32'd0 - n_d) : n_d;

    // Exponential average update, saturated to 48 bits; a zero average takes the new value directly
    assign n_sm_sum = 50'(r_smoothed) - 50'(r_q_sm) + 50'(r_q_x);
    always_comb begin
        if (r_smoothed == 48'sd0) begin
            n_smoothed = {r_x, 16'b0};
        end else if (n_sm_sum > Sat48Max) begin
            n_smoothed = Sat48Max[47:0];
        end else if (n_sm_sum < Sat48Min) begin
            n_smoothed = Sat48Min[47:0];
        end else begin
            n_smoothed = n_sm_sum[47:0];
        end
    end

    // Round half away from zero, saturate to 32 bits
    assign n_mag  = r_smoothed[47] ? 48'(-r_smoothed) : 48'(r_smoothed);
    assign n_rnd  = {1'b0, n_mag} + 49'd32768;
    assign n_rmag = n_rnd[47:16];
    always_comb begin
        if (r_smoothed[47]) begin
            n_report = $signed(32'd0 - n_rmag);
        end else if (n_rmag[31]) begin
            n_report = 32'sh7FFF_FFFF;
        end else begin
            n_report = $signed(n_rmag);
        end
    end

    // Dividend select
    always_comb begin
        case (i_cmd.div_sel)
            bsi_pkg::DSEL_DRIFT:  div_dividend = {r_drift_prod[50], r_drift_prod};
            bsi_pkg::DSEL_SMOOTH: div_dividend = {{4{r_smoothed[47]}}, r_smoothed};
            bsi_pkg::DSEL_X:      div_dividend = {{4{r_x[31]}}, r_x, 16'b0};
            default:              div_dividend = '0;
        endcase
    end

    bsi_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dividend),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // Payload and working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.in_load) begin
            r_alt   <= i_altitude;
            r_now   <= i_time_ms;
            r_noise <= i_noise_sample;
        end
        if (i_cmd.mul) begin
            r_drift_prod <= 51'(r_drift_rate) * 51'($signed({1'b0, r_now}));
            r_noise_prod <= 37'($signed({1'b0, r_noise_scale})) * 37'(r_noise);
            r_target     <= r_now - {22'b0, r_delay};
            r_store      <= n_store;
            r_wslot_idx  <= n_slot_idx;
        end
        if (i_cmd.add_drift) begin
            r_x <= n_x_drift;
        end
        if (i_cmd.add_noise) begin
            r_x <= n_x_noise;
        end
        if (i_cmd.add_glitch) begin
            r_x <= n_x_glitch;
        end
        if (i_cmd.sel_x && r_found) begin
            r_x <= r_smp_v ? r_smp_q : 32'sd0;
        end
        if (i_cmd.sm_latch) begin
            r_q_sm <= div_quo[38:0];
        end
        if (i_cmd.x_latch) begin
            r_q_x <= div_quo[38:0];
        end
        if (i_cmd.scan_rd) begin
            r_stamp_v <= r_valid[i_cmd.scan_addr];
        end
        if (i_cmd.rd_sample) begin
            r_smp_v <= r_valid[r_best_idx];
        end
        // best-match tracking over the scan
        if (i_cmd.scan_clr) begin
            r_best_dist <= 8'(bsi_pkg::MatchWinMs);
            r_best_idx  <= '0;
            r_found     <= 1'b0;
        end else if (i_cmd.cmp_en && (n_dist < {24'b0, r_best_dist})) begin
            r_best_dist <= n_dist[7:0];
            r_best_idx  <= i_cmd.cmp_idx;
            r_found     <= 1'b1;
        end
        if (i_cmd.out_load) begin
            r_out_data <= n_report;
        end
    end

    // Stamp ring
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul && n_store) begin
            stamp_mem[n_slot_idx] <= r_now;
        end
        if (i_cmd.scan_rd) begin
            r_stamp_q <= stamp_mem[i_cmd.scan_addr];
        end
    end

    // Sample ring
    always_ff @(posedge i_clk) begin
        if (i_cmd.add_glitch && r_store) begin
            sample_mem[r_wslot_idx] <= n_x_glitch;
        end
        if (i_cmd.rd_sample) begin
            r_smp_q <= sample_mem[r_best_idx];
        end
    end

    // Persistent state and output handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot       <= '0;
            r_last_store <= '0;
            r_last_rep   <= '0;
            r_smoothed   <= '0;
            r_valid      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.mul && n_store) begin
                r_last_store        <= r_now;
                r_slot              <= n_slot_use + 1'b1;
                r_valid[n_slot_idx] <= 1'b1;
            end
            if (i_cmd.smooth) begin
                r_smoothed <= n_smoothed;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
                r_last_rep  <= r_now;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.disabled = r_disable;
    assign o_sts.div_done = div_done;
    assign o_sts.rep_due  = (r_now - r_last_rep) >= 32'(bsi_pkg::ReportGapMs);
    assign o_sts.out_busy = r_out_valid && i_out_stall;

    assign o_out_valid         = r_out_valid;
    assign o_reported_altitude = r_out_data;

endmodule

// ===== design/bsi_ctrl.sv =====
// Controller of the impaired barometer: item sequencing state machine and
// ring scan address counter. Depends on bsi_pkg.
module bsi_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output bsi_pkg::t_cmd o_cmd,
    input  bsi_pkg::t_sts i_sts
);

    typedef enum logic [14:0] {
        S_IDLE       = 15'b000000000000001,
        S_MUL        = 15'b000000000000010,
        S_DRIFT_GO   = 15'b000000000000100,
        S_DRIFT_WAIT = 15'b000000000001000,
        S_NOISE      = 15'b000000000010000,
        S_GLITCH     = 15'b000000000100000,
        S_SM_GO      = 15'b000000001000000,
        S_SM_WAIT    = 15'b000000010000000,
        S_SCAN_WAIT  = 15'b000000100000000,
        S_READ       = 15'b000001000000000,
        S_SELECT     = 15'b000010000000000,
        S_X_GO       = 15'b000100000000000,
        S_X_WAIT     = 15'b001000000000000,
        S_SMOOTH     = 15'b010000000000000,
        S_REPORT     = 15'b100000000000000
    } t_state;

    t_state                    r_state;
    t_state                    n_state;
    logic                      r_scan_run;
    logic                      r_scan_tail;
    logic [bsi_pkg::IdxW-1:0]  r_scan_cnt;
    logic [bsi_pkg::IdxW-1:0]  r_cmp_idx;
    logic                      scan_done;

    assign scan_done = !r_scan_run && !r_scan_tail;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.div_sel   = bsi_pkg::DSEL_DRIFT;
        o_cmd.scan_rd   = r_scan_run;
        o_cmd.scan_addr = r_scan_cnt;
        o_cmd.cmp_en    = r_scan_tail;
        o_cmd.cmp_idx   = r_cmp_idx;
        case (r_state)
            S_IDLE: begin
                o_cmd.in_load = i_in_valid;
                if (i_in_valid && !i_sts.disabled) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul      = 1'b1;
                o_cmd.scan_clr = 1'b1;
                n_state        = S_DRIFT_GO;
            end
            S_DRIFT_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = bsi_pkg::DSEL_DRIFT;
                n_state         = S_DRIFT_WAIT;
            end
            S_DRIFT_WAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.add_drift = 1'b1;
                    n_state         = S_NOISE;
                end
            end
            S_NOISE: begin
                o_cmd.add_noise = 1'b1;
                n_state         = S_GLITCH;
            end
            S_GLITCH: begin
                o_cmd.add_glitch = 1'b1;
                n_state          = S_SM_GO;
            end
            S_SM_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = bsi_pkg::DSEL_SMOOTH;
                n_state         = S_SM_WAIT;
            end
            S_SM_WAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.sm_latch = 1'b1;
                    n_state        = S_SCAN_WAIT;
                end
            end
            S_SCAN_WAIT: begin
                if (scan_done) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd_sample = 1'b1;
                n_state         = S_SELECT;
            end
            S_SELECT: begin
                o_cmd.sel_x = 1'b1;
                n_state     = S_X_GO;
            end
            S_X_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = bsi_pkg::DSEL_X;
                n_state         = S_X_WAIT;
            end
            S_X_WAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.x_latch = 1'b1;
                    n_state       = S_SMOOTH;
                end
            end
            S_SMOOTH: begin
                o_cmd.smooth = 1'b1;
                n_state      = S_REPORT;
            end
            S_REPORT: begin
                // hold here while the previous result is still stalled
                if (!i_sts.rep_due) begin
                    n_state = S_IDLE;
                end else if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Ring scan: one stamp read per cycle, compare in the cycle after the read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_run  <= 1'b0;
            r_scan_tail <= 1'b0;
            r_scan_cnt  <= '0;
            r_cmp_idx   <= '0;
        end else begin
            r_scan_tail <= r_scan_run;
            r_cmp_idx   <= r_scan_cnt;
            if (r_state == S_MUL) begin
                r_scan_run <= 1'b1;
                r_scan_cnt <= '0;
            end else if (r_scan_run) begin
                r_scan_cnt <= r_scan_cnt + 1'b1;
                if (r_scan_cnt == bsi_pkg::IdxW'(bsi_pkg::RingDepth - 1)) begin
                    r_scan_run <= 1'b0;
                end
            end
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule
